[design/lgs_pkg.sv]
// Shared types and constants for the life generation stencil.
// No dependencies; used by life_generation_stencil.
package lgs_pkg;

  localparam int CFG_W = 7;

  localparam logic REG_BOARD_WIDTH  = 1'b0;
  localparam logic REG_BOARD_HEIGHT = 1'b1;

  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic kind;
    logic cell_alive;
  } in_item_t;

  typedef struct packed {
    logic next_alive;
    logic frame_end;
  } out_item_t;

  // Board edges around the cell that is being evaluated.
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } edge_flags_t;

endpackage

[design/life_generation_stencil.sv]
// Top level of the B3/S23 next-generation stencil (dead border).
// Depends on lgs_pkg, lgs_row_line and lgs_cell.
//
// Usage: the current generation streams in on in_* one cell per item in
// row-major order (kind 0); after the last cell the feeder sends width+1
// flush items (kind 1). Each accepted item after the first width+1 of a
// frame yields one item on out_* with the next state of the cell one row
// plus one column behind it; frame_end marks the last cell of the frame,
// after which the next frame may follow at once.
// Throughput: one item per cycle while in_ready is high, set by the shift
// chain of two row lines and a 3x3 window that all move once per
// accepted item. The item completing a neighborhood enters the evaluation
// stage, and its result is then registered on out_*.
// A stalled receiver holds the output register; items are still taken until
// one of them yields a result, which waits in the evaluation stage, then
// in_ready drops until the output drains.
// cfg_* writes board_width (index 0) or board_height (index 1) at any time
// cfg_ready is high and restart the frame; write only while idle.
// Reset: sizes return to 40 x 40, all pipeline contents are dropped, and the
// stored rows read as dead cells.
module life_generation_stencil #(
  parameter int MAX_SIDE = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lgs_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lgs_pkg::out_item_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0] cfg_data
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int RW = $clog2(MAX_SIDE + 3);

  logic [lgs_pkg::CFG_W-1:0] width_cfg_r;
  logic [lgs_pkg::CFG_W-1:0] height_cfg_r;
  logic [SW-1:0]             w_eff;
  logic [SW-1:0]             h_eff;

  logic [SW-1:0]             in_col_r, in_col_nxt;
  logic [RW-1:0]             in_row_r, in_row_nxt;
  logic [SW-1:0]             out_col_r, out_col_nxt;
  logic [SW-1:0]             out_row_r, out_row_nxt;

  logic                      s1_valid_r, s1_valid_nxt;
  lgs_pkg::edge_flags_t      s1_flags_r, s1_flags_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lgs_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                      in_fire, cfg_fire, stall, s1_move, produce;
  logic                      v_in;
  lgs_pkg::edge_flags_t      flags;
  lgs_pkg::out_item_t        eval;

  // window: k0..k2 newest, k_w..k_w2 one row back, k_2w..k_2w2 two rows back
  logic                      k0_r, k1_r, k2_r;
  logic                      kw_1_r, kw_2_r;
  logic                      k2w_1_r, k2w_2_r;
  logic                      row_a_out, row_b_out;
  logic [lgs_pkg::CNT_W-1:0] count;

  always_comb begin
    w_eff = SW'(width_cfg_r);
    if (width_cfg_r == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_cfg_r) > MAX_SIDE) begin
      w_eff = SW'(MAX_SIDE);
    end
    h_eff = SW'(height_cfg_r);
    if (height_cfg_r == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_cfg_r) > MAX_SIDE) begin
      h_eff = SW'(MAX_SIDE);
    end
  end

  assign stall     = out_valid_r && !out_ready;
  assign in_ready  = !(s1_valid_r && stall);
  assign in_fire   = in_valid && in_ready;
  assign s1_move   = s1_valid_r && !stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  assign v_in    = !in_data.kind && (in_row_r < RW'(h_eff)) && in_data.cell_alive;
  assign produce = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));

  always_comb begin
    flags.top    = (out_row_r == '0);
    flags.bottom = (out_row_r == h_eff - SW'(1));
    flags.left   = (out_col_r == '0);
    flags.right  = (out_col_r == w_eff - SW'(1));
    flags.last   = flags.bottom && flags.right;
  end

  always_comb begin
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    s1_valid_nxt = s1_valid_r;
    s1_flags_nxt = s1_flags_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_col_r == w_eff - SW'(1)) begin
        in_col_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_col_nxt = in_col_r + SW'(1);
      end
      s1_valid_nxt = produce;
      s1_flags_nxt = flags;
      if (produce) begin
        if (flags.right) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + SW'(1);
        end else begin
          out_col_nxt = out_col_r + SW'(1);
        end
        if (flags.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
    if (cfg_fire) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  lgs_row_line #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_row_a (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (in_fire),
    .width(w_eff),
    .din  (k0_r),
    .dout (row_a_out)
  );

  lgs_row_line #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_row_b (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (in_fire),
    .width(w_eff),
    .din  (row_a_out),
    .dout (row_b_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k0_r    <= 1'b0;
      k1_r    <= 1'b0;
      k2_r    <= 1'b0;
      kw_1_r  <= 1'b0;
      kw_2_r  <= 1'b0;
      k2w_1_r <= 1'b0;
      k2w_2_r <= 1'b0;
    end else if (in_fire) begin
      k0_r    <= v_in;
      k1_r    <= k0_r;
      k2_r    <= k1_r;
      kw_1_r  <= row_a_out;
      kw_2_r  <= kw_1_r;
      k2w_1_r <= row_b_out;
      k2w_2_r <= k2w_1_r;
    end
  end

  // neighbor sum with dead cells beyond the board edges
  always_comb begin
    count = lgs_pkg::CNT_W'(k2w_2_r & !s1_flags_r.top & !s1_flags_r.left)
          + lgs_pkg::CNT_W'(k2w_1_r & !s1_flags_r.top)
          + lgs_pkg::CNT_W'(row_b_out & !s1_flags_r.top & !s1_flags_r.right)
          + lgs_pkg::CNT_W'(kw_2_r & !s1_flags_r.left)
          + lgs_pkg::CNT_W'(row_a_out & !s1_flags_r.right)
          + lgs_pkg::CNT_W'(k2_r & !s1_flags_r.bottom & !s1_flags_r.left)
          + lgs_pkg::CNT_W'(k1_r & !s1_flags_r.bottom)
          + lgs_pkg::CNT_W'(k0_r & !s1_flags_r.bottom & !s1_flags_r.right);
    eval.next_alive = (count == lgs_pkg::BIRTH_COUNT)
                   || (kw_1_r && (count == lgs_pkg::SURVIVE_COUNT));
    eval.frame_end  = s1_flags_r.last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!stall) begin
      out_valid_nxt = s1_valid_r;
      out_data_nxt  = eval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= lgs_pkg::CFG_W'(40);
      height_cfg_r <= lgs_pkg::CFG_W'(40);
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          lgs_pkg::REG_BOARD_WIDTH:  width_cfg_r  <= cfg_data;
          lgs_pkg::REG_BOARD_HEIGHT: height_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      out_col_r   <= out_col_nxt;
      out_row_r   <= out_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_flags_r <= s1_flags_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/lgs_cell.sv]
// One storage cell of the stream shift line.
// Depends on nothing; chained by lgs_row_line.
module lgs_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic sel_din,
  input  logic din,
  input  logic prev,
  output logic q
);

  logic q_r;
  logic q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (en) begin
      q_nxt = sel_din ? din : prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= 1'b0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[design/lgs_row_line.sv]
// Row delay of programmable length: a chain of lgs_cell instances.
// Data enters at cell MAX_SIDE-width and leaves at the last cell.
module lgs_row_line #(
  parameter int MAX_SIDE = 64,
  parameter int SW       = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [SW-1:0] width,
  input  logic          din,
  output logic          dout
);

  logic [MAX_SIDE-1:0] q;

  for (genvar i = 0; i < MAX_SIDE; i++) begin : g_cell
    logic prev;
    logic tap;
    if (i == 0) begin : g_head
      assign prev = din;
    end else begin : g_body
      assign prev = q[i-1];
    end
    assign tap = (width == SW'(MAX_SIDE - i));
    lgs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .sel_din(tap),
      .din    (din),
      .prev   (prev),
      .q      (q[i])
    );
  end

  assign dout = q[MAX_SIDE-1];

endmodule
